[rtl/tri_ang_pkg.sv]
// shared constants and the arctangent table for the triangle angle block
// no dependencies; used by every rtl file of the block
`default_nettype none

package tri_ang_pkg;

  localparam int SIDE_WIDTH_DEF     = 24;
  localparam int SIDE_FRAC_BITS_DEF = 8;
  localparam int ARCCOS_ITER_DEF    = 24;

  localparam int MAX_ITER   = 32;  // cordic step cap
  localparam int DIV_STEPS  = 30;  // quotient bits of the q1.30 cosine
  localparam int SQRT_STEPS = 32;  // result bits of the 64-bit square root
  localparam int FIXED_LAT  = 69;  // lane stages apart from the cordic steps

  localparam int DEG_W = 8;
  localparam int MIN_W = 6;
  localparam int SEC_W = 6;
  localparam int ANGLE_W = DEG_W + MIN_W + SEC_W;
  localparam int OUT_TDATA_W = ((3 * ANGLE_W + 7) / 8) * 8;

  // atan(2^-i) in q8.24 degrees, rounded
  function automatic logic [31:0] atan_deg(input int i);
    logic [31:0] t;
    case (i)
      0:  t = 32'd754974720;
      1:  t = 32'd445687602;
      2:  t = 32'd235489088;
      3:  t = 32'd119537938;
      4:  t = 32'd60000934;
      5:  t = 32'd30029717;
      6:  t = 32'd15018523;
      7:  t = 32'd7509720;
      8:  t = 32'd3754917;
      9:  t = 32'd1877466;
      10: t = 32'd938734;
      11: t = 32'd469367;
      12: t = 32'd234684;
      13: t = 32'd117342;
      14: t = 32'd58671;
      15: t = 32'd29335;
      16: t = 32'd14668;
      17: t = 32'd7334;
      18: t = 32'd3667;
      19: t = 32'd1833;
      20: t = 32'd917;
      21: t = 32'd458;
      22: t = 32'd229;
      23: t = 32'd115;
      24: t = 32'd57;
      25: t = 32'd29;
      26: t = 32'd14;
      27: t = 32'd7;
      28: t = 32'd4;
      29: t = 32'd2;
      30: t = 32'd1;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

[rtl/tri_ang_lane.sv]
// one angle lane: law of cosines, cosine divider, sine root, cordic, dms split
// depends on tri_ang_pkg
`default_nettype none

module tri_ang_lane #(
  parameter int XW = tri_ang_pkg::SIDE_WIDTH_DEF,
  parameter int ARCCOS_ITERATIONS = tri_ang_pkg::ARCCOS_ITER_DEF
) (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic [XW-1:0] x,
  input  wire logic [XW-1:0] y,
  input  wire logic [XW-1:0] z,
  output logic [tri_ang_pkg::DEG_W-1:0] deg,
  output logic [tri_ang_pkg::MIN_W-1:0] minutes,
  output logic [tri_ang_pkg::SEC_W-1:0] seconds
);
  import tri_ang_pkg::*;

  localparam int PW  = 2 * XW;
  localparam int DW  = PW + 1;
  localparam int NIT = (ARCCOS_ITERATIONS < MAX_ITER) ? ARCCOS_ITERATIONS : MAX_ITER;
  localparam int VW  = 34;
  localparam int AW  = 35;
  localparam logic [63:0] ONE60 = 64'd1 << 60;
  localparam logic signed [AW-1:0] ANG_90  = AW'(90) << 24;
  localparam logic signed [AW-1:0] ANG_MAX = AW'(180) << 24;

  // products
  logic [PW-1:0] xx, yy, zz, xy;
  always_ff @(posedge clk) begin
    if (en) begin
      xx <= PW'(x) * PW'(x);
      yy <= PW'(y) * PW'(y);
      zz <= PW'(z) * PW'(z);
      xy <= PW'(x) * PW'(y);
    end
  end

  // numerator magnitude, sign and denominator
  logic [PW+1:0] sum2, numv;
  logic          num_neg;
  logic [DW-1:0] mag, den_c;
  assign sum2    = {2'b00, xx} + {2'b00, yy};
  assign numv    = sum2 - {2'b00, zz};
  assign num_neg = numv[PW+1];
  assign mag     = num_neg ? DW'(~numv + 1'b1) : DW'(numv);
  assign den_c   = {xy, 1'b0};

  logic [DW-1:0]        dr   [0:DIV_STEPS];
  logic [DW-1:0]        dden [0:DIV_STEPS];
  logic [DIV_STEPS-1:0] dq   [0:DIV_STEPS];
  logic                 dneg [0:DIV_STEPS];
  logic                 dzero[0:DIV_STEPS];
  logic                 dsat [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      dr[0]    <= mag;
      dden[0]  <= den_c;
      dq[0]    <= '0;
      dneg[0]  <= num_neg;
      dzero[0] <= (den_c == '0);
      dsat[0]  <= (mag >= den_c);
    end
  end

  // restoring divider, one quotient bit a stage
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [DW:0] r2, rs;
    logic        ge;
    assign r2 = {dr[k], 1'b0};
    assign rs = r2 - {1'b0, dden[k]};
    assign ge = (r2 >= {1'b0, dden[k]});
    always_ff @(posedge clk) begin
      if (en) begin
        dr[k+1]    <= ge ? rs[DW-1:0] : r2[DW-1:0];
        dq[k+1]    <= {dq[k][DIV_STEPS-2:0], ge};
        dden[k+1]  <= dden[k];
        dneg[k+1]  <= dneg[k];
        dzero[k+1] <= dzero[k];
        dsat[k+1]  <= dsat[k];
      end
    end
  end

  logic [30:0] q_fin;
  logic [61:0] qq;
  always_comb begin
    if (dzero[DIV_STEPS]) begin
      q_fin = '0;
    end else if (dsat[DIV_STEPS]) begin
      q_fin = 31'd1 << DIV_STEPS;
    end else begin
      q_fin = {1'b0, dq[DIV_STEPS]};
    end
  end
  assign qq = 62'(q_fin) * 62'(q_fin);

  logic [63:0] sv   [0:SQRT_STEPS];
  logic [63:0] sr   [0:SQRT_STEPS];
  logic [30:0] sq   [0:SQRT_STEPS];
  logic        sneg [0:SQRT_STEPS];

  // a cosine that truncates to zero counts as non-negative
  always_ff @(posedge clk) begin
    if (en) begin
      sv[0]   <= ONE60 - {2'b00, qq};
      sr[0]   <= '0;
      sq[0]   <= q_fin;
      sneg[0] <= dneg[DIV_STEPS] && (q_fin != '0);
    end
  end

  // digit-by-digit square root, bit weight 4^(31-k)
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] t;
    logic        ge;
    assign t  = sr[k] + BIT;
    assign ge = (sv[k] >= t);
    always_ff @(posedge clk) begin
      if (en) begin
        sv[k+1]   <= ge ? sv[k] - t : sv[k];
        sr[k+1]   <= ge ? (sr[k] >> 1) + BIT : (sr[k] >> 1);
        sq[k+1]   <= sq[k];
        sneg[k+1] <= sneg[k];
      end
    end
  end

  logic signed [VW-1:0] cvx [0:NIT];
  logic signed [VW-1:0] cvy [0:NIT];
  logic signed [AW-1:0] cang[0:NIT];
  logic signed [VW-1:0] sin_s, cos_s;
  assign sin_s = $signed({3'b000, sr[SQRT_STEPS][30:0]});
  assign cos_s = $signed({3'b000, sq[SQRT_STEPS]});

  // obtuse angles start at 90 degrees with the vector turned
  always_ff @(posedge clk) begin
    if (en) begin
      cvx[0]  <= sneg[SQRT_STEPS] ? sin_s : cos_s;
      cvy[0]  <= sneg[SQRT_STEPS] ? cos_s : sin_s;
      cang[0] <= sneg[SQRT_STEPS] ? ANG_90 : '0;
    end
  end

  for (genvar i = 0; i < NIT; i++) begin : g_cordic
    localparam logic signed [AW-1:0] T = $signed({3'b000, atan_deg(i)});
    logic signed [VW-1:0] dx, dy;
    assign dx = cvy[i] >>> i;
    assign dy = cvx[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (!cvy[i][VW-1]) begin
          cvx[i+1]  <= cvx[i] + dx;
          cvy[i+1]  <= cvy[i] - dy;
          cang[i+1] <= cang[i] + T;
        end else begin
          cvx[i+1]  <= cvx[i] - dx;
          cvy[i+1]  <= cvy[i] + dy;
          cang[i+1] <= cang[i] - T;
        end
      end
    end
  end

  logic [31:0] angq;
  always_ff @(posedge clk) begin
    if (en) begin
      if (cang[NIT][AW-1]) begin
        angq <= '0;
      end else if (cang[NIT] > ANG_MAX) begin
        angq <= ANG_MAX[31:0];
      end else begin
        angq <= cang[NIT][31:0];
      end
    end
  end

  logic [DEG_W-1:0] deg1;
  logic [29:0]      m1;
  always_ff @(posedge clk) begin
    if (en) begin
      deg1 <= angq[31:24];
      m1   <= 30'(angq[23:0]) * 30'd60;
    end
  end

  logic [29:0] s1;
  assign s1 = 30'(m1[23:0]) * 30'd60;
  always_ff @(posedge clk) begin
    if (en) begin
      deg     <= deg1;
      minutes <= m1[29:24];
      seconds <= s1[29:24];
    end
  end

endmodule

`default_nettype wire

[rtl/triangle_angles_from_sides_top.sv]
// top level of the triangle angle block: input check, three angle lanes, output
// depends on tri_ang_pkg and tri_ang_lane
`default_nettype none

// Takes three triangle sides (unsigned fixed point, SIDE_FRAC_BITS fraction
// bits) and returns the three inner angles in whole degrees, arc minutes and
// arc seconds, each truncated. A triangle is accepted when every side is at
// least 1.0 and each side is strictly shorter than the sum of the other two;
// otherwise m_tuser is 0 and all angle fields are 0. Each angle comes from
// the law of cosines: the cosine by a 30-bit restoring divider, the sine by
// a 32-step square root, and the angle by a vectoring cordic. The block is
// fully pipelined and takes one transfer per clock; each item passes the
// input stage, then the product, divider, root, cordic and dms split stages
// of its lane, to the output. When the output is stalled the whole pipe
// holds and s_tready drops.
module triangle_angles_from_sides_top #(
  parameter int SIDE_WIDTH        = tri_ang_pkg::SIDE_WIDTH_DEF,
  parameter int SIDE_FRAC_BITS    = tri_ang_pkg::SIDE_FRAC_BITS_DEF,
  parameter int ARCCOS_ITERATIONS = tri_ang_pkg::ARCCOS_ITER_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  // side_a, side_b, side_c from the lowest bit up, zero fill
  input  wire logic [((3*SIDE_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic      m_tvalid,
  input  wire logic m_tready,
  // opp_c_deg, opp_c_min, opp_c_sec, opp_b_deg, opp_b_min, opp_b_sec,
  // opp_a_deg, opp_a_min, opp_a_sec from the lowest bit up, zero fill
  output logic [tri_ang_pkg::OUT_TDATA_W-1:0] m_tdata,
  // valid_res
  output logic      m_tuser
);
  import tri_ang_pkg::*;

  localparam int SH  = (SIDE_WIDTH > 31) ? SIDE_WIDTH - 31 : 0;
  localparam int XW  = SIDE_WIDTH - SH;
  localparam int NIT = (ARCCOS_ITERATIONS < MAX_ITER) ? ARCCOS_ITERATIONS : MAX_ITER;
  localparam int LAT = FIXED_LAT + NIT;  // lane stages after the input stage
  localparam logic [SIDE_WIDTH:0] ONE = (SIDE_WIDTH+1)'(1) << SIDE_FRAC_BITS;

  logic en;

  // side fields
  logic [SIDE_WIDTH-1:0] side_a, side_b, side_c;
  assign side_a = s_tdata[SIDE_WIDTH-1:0];
  assign side_b = s_tdata[2*SIDE_WIDTH-1:SIDE_WIDTH];
  assign side_c = s_tdata[3*SIDE_WIDTH-1:2*SIDE_WIDTH];

  // validity: all sides at least one and strict triangle inequalities
  logic [SIDE_WIDTH:0] ea, eb, ec;
  logic                tri_ok;
  assign ea = {1'b0, side_a};
  assign eb = {1'b0, side_b};
  assign ec = {1'b0, side_c};
  assign tri_ok = (ea >= ONE) && (eb >= ONE) && (ec >= ONE) &&
                  (ea + eb > ec) && (ea + ec > eb) && (eb + ec > ea);

  // input stage
  logic [XW-1:0] xa, xb, xc;
  always_ff @(posedge clk) begin
    if (en) begin
      xa <= XW'(side_a >> SH);
      xb <= XW'(side_b >> SH);
      xc <= XW'(side_c >> SH);
    end
  end

  // valid bit and triangle flag travel beside the lanes
  logic vld [0:LAT];
  logic ok  [0:LAT];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= LAT; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= s_tvalid;
      for (int k = 1; k <= LAT; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok[0] <= tri_ok;
      for (int k = 1; k <= LAT; k++) begin
        ok[k] <= ok[k-1];
      end
    end
  end

  // pipe advances unless a finished result waits on a stalled sink
  assign en       = !vld[LAT] || m_tready;
  assign s_tready = en;

  logic [DEG_W-1:0] c_deg, b_deg, a_deg;
  logic [MIN_W-1:0] c_min, b_min, a_min;
  logic [SEC_W-1:0] c_sec, b_sec, a_sec;

  // angle between a and b, opposite c
  tri_ang_lane #(.XW(XW), .ARCCOS_ITERATIONS(ARCCOS_ITERATIONS)) u_lane_c (
    .clk(clk), .en(en), .x(xa), .y(xb), .z(xc),
    .deg(c_deg), .minutes(c_min), .seconds(c_sec)
  );

  // angle between a and c, opposite b
  tri_ang_lane #(.XW(XW), .ARCCOS_ITERATIONS(ARCCOS_ITERATIONS)) u_lane_b (
    .clk(clk), .en(en), .x(xa), .y(xc), .z(xb),
    .deg(b_deg), .minutes(b_min), .seconds(b_sec)
  );

  // angle between b and c, opposite a
  tri_ang_lane #(.XW(XW), .ARCCOS_ITERATIONS(ARCCOS_ITERATIONS)) u_lane_a (
    .clk(clk), .en(en), .x(xb), .y(xc), .z(xa),
    .deg(a_deg), .minutes(a_min), .seconds(a_sec)
  );

  logic [3*ANGLE_W-1:0] angles;
  assign angles = {a_sec, a_min, a_deg, b_sec, b_min, b_deg, c_sec, c_min, c_deg};

  // invalid triangles report zero angles
  assign m_tvalid = vld[LAT];
  assign m_tuser  = ok[LAT];
  assign m_tdata  = ok[LAT] ? OUT_TDATA_W'(angles) : '0;

endmodule

`default_nettype wire

[rtl/tri_ang_checker.sv]
// port-level checks for the triangle angle block, bound to the top level
// depends on tri_ang_pkg and triangle_angles_from_sides_top
`default_nettype none

module tri_ang_props (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_tready,
  input wire logic m_tvalid,
  input wire logic m_tready,
  input wire logic [tri_ang_pkg::OUT_TDATA_W-1:0] m_tdata,
  input wire logic m_tuser
);
  import tri_ang_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // no transfer pending means the pipe takes input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty output");

  // rejected triangles carry zero angles
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("nonzero angles on invalid triangle");

  // all degree fields and the minutes and seconds of the angle opposite c stay in range
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:0] <= 8'd180 && m_tdata[13:8] <= 6'd59 &&
                 m_tdata[19:14] <= 6'd59 && m_tdata[27:20] <= 8'd180 &&
                 m_tdata[47:40] <= 8'd180)
    else $error("angle field out of range");

  // nothing leaves right after reset
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind triangle_angles_from_sides_top tri_ang_props u_tri_ang_props (
  .clk(clk), .rst(rst), .s_tready(s_tready), .m_tvalid(m_tvalid),
  .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

`default_nettype wire
